@@ rtl/morse_symbol_decoder_top_defines.svh @@
// assertion macros for the morse symbol decoder
`ifndef MORSE_SYMBOL_DECODER_TOP_DEFINES_SVH
`define MORSE_SYMBOL_DECODER_TOP_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define MSD_ASSERT(label, prop) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("morse decoder check failed");
`define MSD_ASSERT_RST(label, prop) \
    label: assert property (@(posedge aclk) prop) \
        else $error("morse decoder reset check failed");
`else
`define MSD_ASSERT(label, prop)
`define MSD_ASSERT_RST(label, prop)
`endif
`endif

@@ rtl/msd_pkg.sv @@
// types, constants and decode tree for the morse symbol decoder
package msd_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int OUT_COUNT_WIDTH = 16;
    localparam int COUNT_EXT_WIDTH =
        (COUNT_WIDTH > OUT_COUNT_WIDTH) ? COUNT_WIDTH : OUT_COUNT_WIDTH;

    localparam logic [7:0] SYM_DOT   = 8'h2E;
    localparam logic [7:0] SYM_DASH  = 8'h2D;
    localparam logic [7:0] SYM_SPACE = 8'h20;

    localparam logic [6:0] CH_0 = 7'h30;
    localparam logic [6:0] CH_9 = 7'h39;
    localparam logic [6:0] CH_A = 7'h61;
    localparam logic [6:0] CH_Z = 7'h7A;

    localparam logic [5:0] POS_ROOT = 6'd1;

    localparam logic [1:0] ERR_NONE = 2'd0;
    localparam logic [1:0] ERR_SEQ  = 2'd1;
    localparam logic [1:0] ERR_CHAR = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [7:0] symbol;
        logic       last;
    } msd_in_t;

    typedef struct packed {
        logic        char_valid;
        logic [6:0]  decoded_char;
        logic [1:0]  error_code;
        logic        end_of_message;
        logic [15:0] letter_count;
        logic [15:0] digit_count;
        logic [15:0] dot_count;
        logic [15:0] dash_count;
    } msd_out_t;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] decoded_char;
        logic [1:0] error_code;
        logic       end_of_message;
    } msd_res_t;

    typedef struct packed {
        logic clear;
        logic dot;
        logic dash;
        logic letter;
        logic digit;
    } msd_cnt_ctl_t;

    function automatic logic [6:0] node_char(input logic [5:0] idx);
        logic [6:0] ch;
        case (idx)
            6'd2:  ch = 7'("e");
            6'd3:  ch = 7'("t");
            6'd4:  ch = 7'("i");
            6'd5:  ch = 7'("a");
            6'd6:  ch = 7'("n");
            6'd7:  ch = 7'("m");
            6'd8:  ch = 7'("s");
            6'd9:  ch = 7'("u");
            6'd10: ch = 7'("r");
            6'd11: ch = 7'("w");
            6'd12: ch = 7'("d");
            6'd13: ch = 7'("k");
            6'd14: ch = 7'("g");
            6'd15: ch = 7'("o");
            6'd16: ch = 7'("h");
            6'd17: ch = 7'("v");
            6'd18: ch = 7'("f");
            6'd19: ch = 7'(" ");
            6'd20: ch = 7'("l");
            6'd22: ch = 7'("p");
            6'd23: ch = 7'("j");
            6'd24: ch = 7'("b");
            6'd25: ch = 7'("x");
            6'd26: ch = 7'("c");
            6'd27: ch = 7'("y");
            6'd28: ch = 7'("z");
            6'd29: ch = 7'("q");
            6'd30: ch = 7'(" ");
            6'd31: ch = 7'(" ");
            6'd32: ch = 7'("5");
            6'd33: ch = 7'("4");
            6'd35: ch = 7'("3");
            6'd39: ch = 7'("2");
            6'd47: ch = 7'("1");
            6'd48: ch = 7'("6");
            6'd56: ch = 7'("7");
            6'd60: ch = 7'("8");
            6'd62: ch = 7'("9");
            6'd63: ch = 7'("0");
            default: ch = 7'd0;
        endcase
        return ch;
    endfunction

    function automatic logic [COUNT_WIDTH-1:0] sat_inc(
        input logic [COUNT_WIDTH-1:0] v,
        input logic                   en
    );
        logic [COUNT_WIDTH-1:0] r;
        if (en && (v != {COUNT_WIDTH{1'b1}})) begin
            r = v + COUNT_WIDTH'(1);
        end else begin
            r = v;
        end
        return r;
    endfunction

    function automatic logic [OUT_COUNT_WIDTH-1:0] count_view(
        input logic [COUNT_WIDTH-1:0] v
    );
        logic [COUNT_EXT_WIDTH-1:0] ext;
        ext = COUNT_EXT_WIDTH'(v);
        return ext[OUT_COUNT_WIDTH-1:0];
    endfunction

endpackage

@@ rtl/msd_step.sv @@
// tree walk and result logic for one symbol
module msd_step (
    input  msd_pkg::msd_in_t     item,
    input  logic [5:0]           pos,
    input  logic                 skip,
    output logic [5:0]           pos_next,
    output logic                 skip_next,
    output msd_pkg::msd_res_t    res,
    output msd_pkg::msd_cnt_ctl_t ctl
);
    import msd_pkg::*;

    logic       finish;
    logic [1:0] err;
    logic [5:0] cand;
    logic [5:0] walk;
    logic [6:0] ch;

    always_comb begin
        finish    = 1'b0;
        err       = ERR_NONE;
        walk      = pos;
        skip_next = skip;
        pos_next  = pos;
        ctl       = '0;
        res       = '0;
        res.end_of_message = item.last;
        cand      = {pos[4:0], (item.symbol == SYM_DASH)};
        if (item.cmd) begin
            ctl.clear = 1'b1;
            res.end_of_message = 1'b0;
        end else if (skip) begin
            if (item.last) begin
                skip_next = 1'b0;
                pos_next  = POS_ROOT;
            end
        end else if (item.symbol == SYM_DOT || item.symbol == SYM_DASH) begin
            ctl.dot  = (item.symbol == SYM_DOT);
            ctl.dash = (item.symbol == SYM_DASH);
            if (pos != 6'd0 && !pos[5] && node_char(cand) != 7'd0) begin
                walk     = cand;
                pos_next = cand;
                finish   = item.last;
            end else begin
                err = ERR_SEQ;
            end
        end else if (item.symbol == SYM_SPACE) begin
            finish = 1'b1;
        end else begin
            err = ERR_CHAR;
        end

        ch = node_char(walk);
        res.error_code = err;
        if (err != ERR_NONE) begin
            pos_next  = POS_ROOT;
            skip_next = !item.last;
        end else if (finish) begin
            if (walk != POS_ROOT && ch != 7'd0) begin
                res.char_valid   = 1'b1;
                res.decoded_char = ch;
                ctl.digit  = (ch inside {[CH_0:CH_9]});
                ctl.letter = (ch inside {[CH_A:CH_Z]});
            end
            pos_next = POS_ROOT;
        end
    end

endmodule

@@ rtl/msd_counters.sv @@
// saturating statistics counters
module msd_counters (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  en,
    input  msd_pkg::msd_cnt_ctl_t ctl,
    output logic [msd_pkg::OUT_COUNT_WIDTH-1:0] letter_count,
    output logic [msd_pkg::OUT_COUNT_WIDTH-1:0] digit_count,
    output logic [msd_pkg::OUT_COUNT_WIDTH-1:0] dot_count,
    output logic [msd_pkg::OUT_COUNT_WIDTH-1:0] dash_count
);
    import msd_pkg::*;
    `include "morse_symbol_decoder_top_defines.svh"

    logic [COUNT_WIDTH-1:0] letter_reg, letter_next;
    logic [COUNT_WIDTH-1:0] digit_reg, digit_next;
    logic [COUNT_WIDTH-1:0] dot_reg, dot_next;
    logic [COUNT_WIDTH-1:0] dash_reg, dash_next;

    always_comb begin
        letter_next = letter_reg;
        digit_next  = digit_reg;
        dot_next    = dot_reg;
        dash_next   = dash_reg;
        if (en) begin
            if (ctl.clear) begin
                letter_next = '0;
                digit_next  = '0;
                dot_next    = '0;
                dash_next   = '0;
            end else begin
                letter_next = sat_inc(letter_reg, ctl.letter);
                digit_next  = sat_inc(digit_reg, ctl.digit);
                dot_next    = sat_inc(dot_reg, ctl.dot);
                dash_next   = sat_inc(dash_reg, ctl.dash);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            letter_reg <= '0;
            digit_reg  <= '0;
            dot_reg    <= '0;
            dash_reg   <= '0;
        end else begin
            letter_reg <= letter_next;
            digit_reg  <= digit_next;
            dot_reg    <= dot_next;
            dash_reg   <= dash_next;
        end
    end

    assign letter_count = count_view(letter_reg);
    assign digit_count  = count_view(digit_reg);
    assign dot_count    = count_view(dot_reg);
    assign dash_count   = count_view(dash_reg);

    // clear wins and zeroes everything
    `MSD_ASSERT(a_clear_zero, (en && ctl.clear) |=> (letter_reg == '0 && digit_reg == '0 && dot_reg == '0 && dash_reg == '0))
    // counters only move on a processed item
    `MSD_ASSERT(a_hold_idle, !en |=> ($stable(letter_reg) && $stable(digit_reg) && $stable(dot_reg) && $stable(dash_reg)))
    // a decoded character is never both letter and digit
    `MSD_ASSERT(a_class_excl, !(ctl.letter && ctl.digit))

endmodule

@@ rtl/morse_symbol_decoder_top.sv @@
// morse symbol decoder top level with input and result registers
// Decodes one ASCII Morse symbol (dot, dash, space) per transfer and returns one
// result per item. An item is taken into an input register, walked through the
// decode tree combinationally and written into the result register together with
// the tree position, skip flag and statistics counters when the result register
// is empty or being taken (m_ready); a new item can be taken every cycle while
// m_ready does not hold the result register back.
// s_ready follows m_ready combinationally through the result register stage.
module morse_symbol_decoder_top (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  msd_pkg::msd_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output msd_pkg::msd_out_t m_data
);
    import msd_pkg::*;
    `include "morse_symbol_decoder_top_defines.svh"

    logic         in_valid_reg, in_valid_next;
    msd_in_t      in_reg;
    logic         out_valid_reg, out_valid_next;
    msd_res_t     res_reg;
    logic [5:0]   pos_reg, pos_next;
    logic         skip_reg, skip_next;
    logic [5:0]   step_pos;
    logic         step_skip;
    msd_res_t     step_res;
    msd_cnt_ctl_t step_ctl;
    logic         adv;
    logic [OUT_COUNT_WIDTH-1:0] letter_count;
    logic [OUT_COUNT_WIDTH-1:0] digit_count;
    logic [OUT_COUNT_WIDTH-1:0] dot_count;
    logic [OUT_COUNT_WIDTH-1:0] dash_count;

    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    msd_step u_step (
        .item      (in_reg),
        .pos       (pos_reg),
        .skip      (skip_reg),
        .pos_next  (step_pos),
        .skip_next (step_skip),
        .res       (step_res),
        .ctl       (step_ctl)
    );

    msd_counters u_counters (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .en           (adv),
        .ctl          (step_ctl),
        .letter_count (letter_count),
        .digit_count  (digit_count),
        .dot_count    (dot_count),
        .dash_count   (dash_count)
    );

    always_comb begin
        in_valid_next  = in_valid_reg;
        out_valid_next = out_valid_reg;
        pos_next       = pos_reg;
        skip_next      = skip_reg;
        if (s_ready) begin
            in_valid_next = s_valid;
        end
        if (adv) begin
            out_valid_next = 1'b1;
            pos_next       = step_pos;
            skip_next      = step_skip;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            pos_reg       <= POS_ROOT;
            skip_reg      <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            pos_reg       <= pos_next;
            skip_reg      <= skip_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (adv) begin
            res_reg <= step_res;
        end
    end

    assign m_valid = out_valid_reg;

    always_comb begin
        m_data                = '0;
        m_data.char_valid     = res_reg.char_valid;
        m_data.decoded_char   = res_reg.decoded_char;
        m_data.error_code     = res_reg.error_code;
        m_data.end_of_message = res_reg.end_of_message;
        m_data.letter_count   = letter_count;
        m_data.digit_count    = digit_count;
        m_data.dot_count      = dot_count;
        m_data.dash_count     = dash_count;
    end

    // an error sends the walk back to the root
    `MSD_ASSERT(a_err_root, (adv && step_res.error_code != ERR_NONE) |=> (pos_reg == POS_ROOT))
    // a result never carries both a character and an error
    `MSD_ASSERT(a_char_no_err, (m_valid && m_data.char_valid) |-> (m_data.error_code == ERR_NONE))
    // the tree position never leaves the tree
    `MSD_ASSERT_RST(a_pos_nonzero, $past(aresetn) |-> (pos_reg != 6'd0))

endmodule
